// File: rtl/tfv_pkg.sv
// ----------------------------------------------------------------------------
// tfv_pkg
// Shared types and constants for the timestamp format validator: character
// codes, string positions, field ranges and the per-character check result.
// ----------------------------------------------------------------------------
`default_nettype none

package tfv_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 5;
  localparam int unsigned DigW  = 4;
  localparam int unsigned ValW  = 7;

  // Character codes
  localparam logic [CharW-1:0] CH_DASH  = 8'h2D;
  localparam logic [CharW-1:0] CH_T     = 8'h54;
  localparam logic [CharW-1:0] CH_COLON = 8'h3A;
  localparam logic [CharW-1:0] CH_Z     = 8'h5A;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;

  // Positions of the separators
  localparam logic [PosW-1:0] POS_YM_SEP = 5'd4;
  localparam logic [PosW-1:0] POS_MD_SEP = 5'd7;
  localparam logic [PosW-1:0] POS_DT_SEP = 5'd10;
  localparam logic [PosW-1:0] POS_HM_SEP = 5'd13;
  localparam logic [PosW-1:0] POS_MS_SEP = 5'd16;
  localparam logic [PosW-1:0] POS_ZONE   = 5'd19;
  localparam logic [PosW-1:0] POS_ZC_SEP = 5'd22;
  localparam logic [PosW-1:0] POS_SAT    = 5'd25;

  // Tens digits of the two-digit fields
  localparam logic [PosW-1:0] POS_MON_T  = 5'd5;
  localparam logic [PosW-1:0] POS_DAY_T  = 5'd8;
  localparam logic [PosW-1:0] POS_HR_T   = 5'd11;
  localparam logic [PosW-1:0] POS_MIN_T  = 5'd14;
  localparam logic [PosW-1:0] POS_SEC_T  = 5'd17;
  localparam logic [PosW-1:0] POS_ZHR_T  = 5'd20;
  localparam logic [PosW-1:0] POS_ZMIN_T = 5'd23;

  // Units digits of the two-digit fields
  localparam logic [PosW-1:0] POS_MON_U  = 5'd6;
  localparam logic [PosW-1:0] POS_DAY_U  = 5'd9;
  localparam logic [PosW-1:0] POS_HR_U   = 5'd12;
  localparam logic [PosW-1:0] POS_MIN_U  = 5'd15;
  localparam logic [PosW-1:0] POS_SEC_U  = 5'd18;
  localparam logic [PosW-1:0] POS_ZHR_U  = 5'd21;
  localparam logic [PosW-1:0] POS_ZMIN_U = 5'd24;

  // Last index of the two accepted layouts
  localparam logic [PosW-1:0] POS_END_Z   = 5'd19;
  localparam logic [PosW-1:0] POS_END_OFS = 5'd24;

  // Field ranges
  localparam logic [ValW-1:0] MON_MAX = 7'd12;
  localparam logic [ValW-1:0] DAY_MAX = 7'd31;
  localparam logic [ValW-1:0] HR_MAX  = 7'd23;
  localparam logic [ValW-1:0] MS_MAX  = 7'd59;
  localparam logic [ValW-1:0] ONE     = 7'd1;

  // Outcome of checking one character
  typedef struct packed {
    logic            bad;
    logic            tens_ld;
    logic [DigW-1:0] tens_val;
    logic            zone_ld;
    logic            zone_val;
  } chk_t;

endpackage

`default_nettype wire

// File: rtl/tfv_char_check.sv
// ----------------------------------------------------------------------------
// tfv_char_check
// Checks one character against the layout at its position and the range of
// the two-digit field it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module tfv_char_check (
  input  wire logic [tfv_pkg::CharW-1:0] char_i,
  input  wire logic [tfv_pkg::PosW-1:0]  pos_i,
  input  wire logic [tfv_pkg::DigW-1:0]  tens_i,
  output tfv_pkg::chk_t                  chk_o
);

  logic                       digit;
  logic [tfv_pkg::DigW-1:0]   dval;
  logic [tfv_pkg::ValW-1:0]   tens_ext;
  logic [tfv_pkg::ValW-1:0]   pair;

  // Decode the digit and form the two-digit value (tens * 10 + units)
  assign digit    = (char_i >= tfv_pkg::CH_ZERO) && (char_i <= tfv_pkg::CH_NINE);
  assign dval     = digit ? char_i[tfv_pkg::DigW-1:0] : '0;
  assign tens_ext = {{(tfv_pkg::ValW-tfv_pkg::DigW){1'b0}}, tens_i};
  assign pair     = (tens_ext << 3) + (tens_ext << 1)
                  + {{(tfv_pkg::ValW-tfv_pkg::DigW){1'b0}}, dval};

  // Check the character for its position
  always_comb begin
    chk_o          = '0;
    chk_o.tens_val = dval;
    case (pos_i)
      tfv_pkg::POS_YM_SEP, tfv_pkg::POS_MD_SEP: begin
        chk_o.bad = (char_i != tfv_pkg::CH_DASH);
      end
      tfv_pkg::POS_DT_SEP: begin
        chk_o.bad = (char_i != tfv_pkg::CH_T);
      end
      tfv_pkg::POS_HM_SEP, tfv_pkg::POS_MS_SEP, tfv_pkg::POS_ZC_SEP: begin
        chk_o.bad = (char_i != tfv_pkg::CH_COLON);
      end
      tfv_pkg::POS_ZONE: begin
        if (char_i == tfv_pkg::CH_Z) begin
          chk_o.zone_ld  = 1'b1;
          chk_o.zone_val = 1'b0;
        end else if ((char_i == tfv_pkg::CH_PLUS) || (char_i == tfv_pkg::CH_DASH)) begin
          chk_o.zone_ld  = 1'b1;
          chk_o.zone_val = 1'b1;
        end else begin
          chk_o.bad = 1'b1;
        end
      end
      tfv_pkg::POS_SAT: begin
        chk_o.bad = 1'b1;
      end
      default: begin
        if (!digit) begin
          chk_o.bad = 1'b1;
        end else begin
          case (pos_i)
            tfv_pkg::POS_MON_T, tfv_pkg::POS_DAY_T, tfv_pkg::POS_HR_T,
            tfv_pkg::POS_MIN_T, tfv_pkg::POS_SEC_T, tfv_pkg::POS_ZHR_T,
            tfv_pkg::POS_ZMIN_T: begin
              chk_o.tens_ld = 1'b1;
            end
            tfv_pkg::POS_MON_U: begin
              chk_o.bad = (pair < tfv_pkg::ONE) || (pair > tfv_pkg::MON_MAX);
            end
            tfv_pkg::POS_DAY_U: begin
              chk_o.bad = (pair < tfv_pkg::ONE) || (pair > tfv_pkg::DAY_MAX);
            end
            tfv_pkg::POS_HR_U, tfv_pkg::POS_ZHR_U: begin
              chk_o.bad = (pair > tfv_pkg::HR_MAX);
            end
            tfv_pkg::POS_MIN_U, tfv_pkg::POS_SEC_U, tfv_pkg::POS_ZMIN_U: begin
              chk_o.bad = (pair > tfv_pkg::MS_MAX);
            end
            default: begin
              chk_o.bad = 1'b0;
            end
          endcase
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/timestamp_format_validator_core.sv
// ----------------------------------------------------------------------------
// timestamp_format_validator_core
// Streaming validator for fixed-layout timestamps, one character per
// transfer, one verdict per string.
// ----------------------------------------------------------------------------
//  Channel   | Dir | tdata           | tlast            | Transfer
//  s_axis    | in  | [7:0] character | last character   | tvalid & tready
//  m_axis    | out | [0] valid_res   | -                | tvalid & tready
//
//  One character per cycle, back to back, unless a held verdict stalls input;
//  a string's verdict is registered after its last character is checked.
//  Characters pass an input register, then one check stage that updates the
//  string state and loads the result register on the last character.
//  Reset clears the input and result valids and all string state.
//  A last character waits in the input register only while an earlier verdict
//  is held by m_axis_tready_i low; s_axis_tready_o then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_format_validator_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] character
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] valid_res, [7:1] zero
);

  logic                        in_vld_q, in_vld_d;
  logic [tfv_pkg::CharW-1:0]   in_char_q, in_char_d;
  logic                        in_last_q, in_last_d;
  logic [tfv_pkg::PosW-1:0]    pos_q, pos_d;
  logic                        failed_q, failed_d;
  logic [tfv_pkg::DigW-1:0]    tens_q, tens_d;
  logic                        zone_q, zone_d;
  logic                        out_vld_q, out_vld_d;
  logic                        out_res_q, out_res_d;

  tfv_pkg::chk_t               chk;
  logic                        proceed;
  logic                        fire;
  logic                        failed_nx;
  logic                        zone_nx;
  logic                        ok;

  tfv_char_check u_check (
    .char_i (in_char_q),
    .pos_i  (pos_q),
    .tens_i (tens_q),
    .chk_o  (chk)
  );

  // Stall the check stage only when a verdict has no room
  assign proceed         = !in_last_q || !out_vld_q || m_axis_tready_i;
  assign fire            = in_vld_q && proceed;
  assign s_axis_tready_o = !in_vld_q || proceed;

  assign failed_nx = failed_q | chk.bad;
  assign zone_nx   = chk.zone_ld ? chk.zone_val : zone_q;
  assign ok        = !failed_nx &&
                     (((pos_q == tfv_pkg::POS_END_Z) && !zone_nx) ||
                      ((pos_q == tfv_pkg::POS_END_OFS) && zone_nx));

  // Load the input register
  always_comb begin
    in_vld_d  = in_vld_q;
    in_char_d = in_char_q;
    in_last_d = in_last_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_d  = 1'b1;
      in_char_d = s_axis_tdata_i;
      in_last_d = s_axis_tlast_i;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  // Advance the string state; clear it after the last character
  always_comb begin
    pos_d    = pos_q;
    failed_d = failed_q;
    tens_d   = tens_q;
    zone_d   = zone_q;
    if (fire) begin
      if (in_last_q) begin
        pos_d    = '0;
        failed_d = 1'b0;
        tens_d   = '0;
        zone_d   = 1'b0;
      end else begin
        failed_d = failed_nx;
        zone_d   = zone_nx;
        if (chk.tens_ld) begin
          tens_d = chk.tens_val;
        end
        if (pos_q != tfv_pkg::POS_SAT) begin
          pos_d = pos_q + tfv_pkg::PosW'(1);
        end
      end
    end
  end

  // Load or drain the result register
  always_comb begin
    out_vld_d = out_vld_q;
    out_res_d = out_res_q;
    if (fire && in_last_q) begin
      out_vld_d = 1'b1;
      out_res_d = ok;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pos_q     <= '0;
      failed_q  <= 1'b0;
      tens_q    <= '0;
      zone_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      pos_q     <= pos_d;
      failed_q  <= failed_d;
      tens_q    <= tens_d;
      zone_q    <= zone_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_char_q <= in_char_d;
    in_last_q <= in_last_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0000000, out_res_q};

endmodule

`default_nettype wire

// File: rtl/tfv_checker.sv
// ----------------------------------------------------------------------------
// tfv_checker
// Port-level checks on the timestamp format validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tfv_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       s_axis_tlast_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  // A stalled verdict holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("verdict changed while stalled");

  // Input back-pressure only comes from a stalled verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a held verdict");

  // A new verdict follows a last-character transfer through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |->
      $past(s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, 2))
    else $error("verdict without a last character");

endmodule

bind timestamp_format_validator_core tfv_checker u_tfv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
